/* src/sexp_tok_pkg.sv */
// Package for the S-expression tokenizer: token and scan-mode types, character
// codes, saturation limits and the token record shared by the scanner and queue.
// No dependencies.
package sexp_tok_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LINE_BITS   = 32;
    localparam int NUM_BITS    = 64;
    localparam int OUT_BITS    = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [LINE_BITS-1:0]   line_t;

    typedef enum logic [2:0] {
        KIND_OPEN  = 3'd0,
        KIND_CLOSE = 3'd1,
        KIND_DOT   = 3'd2,
        KIND_QUOTE = 3'd3,
        KIND_SYM   = 3'd4,
        KIND_NUM   = 3'd5,
        KIND_END   = 3'd6,
        KIND_ERR   = 3'd7
    } token_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_MINUS   = 3'd2,
        MODE_NUMBER  = 3'd3,
        MODE_SYMBOL  = 3'd4,
        MODE_BAR     = 3'd5
    } scan_mode_t;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_OPEN      = 8'h28;
    localparam logic [7:0] CH_CLOSE     = 8'h29;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_BAR       = 8'h7C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;

    localparam logic [NUM_BITS-1:0] POS_LIMIT = {1'b0, {(NUM_BITS-1){1'b1}}};
    localparam logic [NUM_BITS-1:0] NEG_LIMIT = {1'b1, {(NUM_BITS-1){1'b0}}};
    localparam line_t               LINE_MAX  = '1;

    typedef struct packed {
        token_kind_t               kind;
        logic signed [NUM_BITS-1:0] num;
        logic [OUT_BITS-1:0]       start;
        logic [OUT_BITS-1:0]       len;
        logic [OUT_BITS-1:0]       line;
        logic                      last;
    } token_t;

    typedef struct packed {
        logic valid;
        logic room;
    } outq_status_t;

endpackage

/* src/sexp_tok_scan.sv */
// Scanner for the S-expression tokenizer: holds the scan state registers and
// turns one accepted byte into zero, one or two tokens.
// Depends on sexp_tok_pkg.
module sexp_tok_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_input,
    output sexp_tok_pkg::token_t tok0,
    output sexp_tok_pkg::token_t tok1,
    output logic [1:0]           tok_count
);
    import sexp_tok_pkg::*;

    scan_mode_t          mode_reg, mode_next;
    logic [NUM_BITS-1:0] acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic                sat_reg, sat_next;
    offset_t             start_reg, start_next;
    offset_t             offset_reg, offset_next;
    line_t               line_reg, line_next;

    logic is_space, is_digit, is_sym;
    logic [3:0] digit;

    assign is_space = (data_byte inside {CH_SPACE, [CH_TAB:CH_CR]});
    assign is_digit = (data_byte inside {[CH_ZERO:CH_NINE]});
    assign is_sym   = !is_space && !(data_byte inside {CH_NUL, CH_OPEN, CH_CLOSE, CH_QUOTE,
                                                       CH_SEMI, CH_BACKSLASH, CH_BAR});
    assign digit    = data_byte[3:0];

    // Which actions this byte triggers.
    logic pending, do_flush, do_idle, idle_emits, bump;
    logic start_num, start_neg;

    assign pending = (mode_reg == MODE_MINUS) || (mode_reg == MODE_NUMBER) ||
                     (mode_reg == MODE_SYMBOL) || (mode_reg == MODE_BAR);

    always_comb
    begin
        do_idle = 1'b0;
        do_flush = 1'b0;
        if (end_of_input)
        begin
            do_flush = pending;
        end
        else
        begin
            case (mode_reg)
                MODE_COMMENT: ;
                MODE_MINUS, MODE_NUMBER:
                begin
                    do_flush = !is_digit;
                    do_idle  = !is_digit;
                end
                MODE_SYMBOL:
                begin
                    do_flush = !is_sym;
                    do_idle  = !is_sym;
                end
                MODE_BAR:    do_flush = (data_byte == CH_BAR);
                default:     do_idle  = 1'b1;
            endcase
        end
    end

    assign idle_emits = (data_byte inside {CH_OPEN, CH_CLOSE, CH_QUOTE, CH_DOT,
                                           CH_NUL, CH_BACKSLASH});
    assign bump = !end_of_input && (data_byte == CH_NEWLINE) &&
                  (do_idle || (mode_reg == MODE_COMMENT));
    assign start_neg = !end_of_input && (mode_reg == MODE_MINUS) && is_digit;
    assign start_num = start_neg || (do_idle && is_digit);

    // Digit accumulation with saturation: acc*10+d is compared with the limit.
    logic [NUM_BITS-1:0] acc_base, limit;
    logic                sat_base, neg_new;
    logic [NUM_BITS+3:0] prod;

    assign acc_base = start_num ? '0 : acc_reg;
    assign sat_base = start_num ? 1'b0 : sat_reg;
    assign neg_new  = start_num ? start_neg : neg_reg;
    assign limit    = neg_new ? NEG_LIMIT : POS_LIMIT;
    assign prod     = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1) +
                      {{(NUM_BITS){1'b0}}, digit};

    // Next scan state.
    always_comb
    begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        sat_next    = sat_reg;
        start_next  = start_reg;
        offset_next = offset_reg;
        line_next   = line_reg;
        if (!end_of_input)
        begin
            offset_next = offset_reg + offset_t'(1);
        end
        if (bump && (line_reg != LINE_MAX))
        begin
            line_next = line_reg + line_t'(1);
        end
        if (do_flush || end_of_input)
        begin
            mode_next = MODE_IDLE;
        end
        if (!end_of_input && (mode_reg == MODE_COMMENT) && (data_byte == CH_NEWLINE))
        begin
            mode_next = MODE_IDLE;
        end
        if (do_idle)
        begin
            mode_next = MODE_IDLE;
            if (data_byte == CH_SEMI)
            begin
                mode_next = MODE_COMMENT;
            end
            else if (data_byte == CH_MINUS)
            begin
                mode_next  = MODE_MINUS;
                start_next = offset_reg;
            end
            else if (data_byte == CH_BAR)
            begin
                mode_next  = MODE_BAR;
                start_next = offset_reg + offset_t'(1);
            end
            else if (is_digit)
            begin
                mode_next = MODE_NUMBER;
            end
            else if (is_sym && (data_byte != CH_DOT))
            begin
                mode_next  = MODE_SYMBOL;
                start_next = offset_reg;
            end
        end
        if (start_neg)
        begin
            mode_next = MODE_NUMBER;
        end
        if (start_num || (!end_of_input && (mode_reg == MODE_NUMBER) && is_digit))
        begin
            neg_next = neg_new;
            sat_next = sat_base;
            acc_next = acc_base;
            if (!sat_base)
            begin
                if (prod > {4'b0, limit})
                begin
                    acc_next = limit;
                    sat_next = 1'b1;
                end
                else
                begin
                    acc_next = prod[NUM_BITS-1:0];
                end
            end
        end
    end

    // Token outputs: the flushed token comes first, then the new one.
    token_t flush_tok, new_tok;
    logic   new_valid;
    offset_t sym_len;

    assign sym_len = offset_reg - start_reg;

    always_comb
    begin
        flush_tok       = '0;
        flush_tok.kind  = KIND_SYM;
        flush_tok.line  = OUT_BITS'(line_reg);
        flush_tok.start = OUT_BITS'(start_reg);
        flush_tok.len   = OUT_BITS'(sym_len);
        if (mode_reg == MODE_MINUS)
        begin
            flush_tok.len = OUT_BITS'(1);
        end
        else if (mode_reg == MODE_NUMBER)
        begin
            flush_tok.kind  = KIND_NUM;
            flush_tok.start = '0;
            flush_tok.len   = '0;
            flush_tok.num   = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
        end
    end

    always_comb
    begin
        new_tok      = '0;
        new_tok.line = OUT_BITS'(line_reg);
        new_valid    = end_of_input || (do_idle && idle_emits);
        if (end_of_input)
        begin
            new_tok.kind = KIND_END;
        end
        else
        begin
            case (data_byte)
                CH_OPEN:  new_tok.kind = KIND_OPEN;
                CH_CLOSE: new_tok.kind = KIND_CLOSE;
                CH_QUOTE: new_tok.kind = KIND_QUOTE;
                CH_DOT:   new_tok.kind = KIND_DOT;
                default:  new_tok.kind = KIND_ERR;
            endcase
        end
    end

    always_comb
    begin
        tok0 = flush_tok;
        tok1 = new_tok;
        tok1.last = 1'b1;
        if (do_flush && new_valid)
        begin
            tok_count = 2'd2;
        end
        else if (do_flush)
        begin
            tok_count = 2'd1;
            tok0.last = 1'b1;
        end
        else if (new_valid)
        begin
            tok_count = 2'd1;
            tok0 = new_tok;
            tok0.last = 1'b1;
        end
        else
        begin
            tok_count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            sat_reg    <= 1'b0;
            start_reg  <= '0;
            offset_reg <= '0;
            line_reg   <= line_t'(1);
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            sat_reg    <= sat_next;
            start_reg  <= start_next;
            offset_reg <= offset_next;
            line_reg   <= line_next;
        end
    end

endmodule

/* src/sexp_tok_outq.sv */
// Output queue for the S-expression tokenizer: a short shifting queue of token
// records that takes up to two tokens and gives one per cycle while pop is held.
// Depends on sexp_tok_pkg.
module sexp_tok_outq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 push_count,
    input  sexp_tok_pkg::token_t       tok0,
    input  sexp_tok_pkg::token_t       tok1,
    input  logic                       pop,
    output sexp_tok_pkg::token_t       head,
    output sexp_tok_pkg::outq_status_t status
);
    import sexp_tok_pkg::*;

    token_t                q_reg [QUEUE_DEPTH];
    token_t                q_next [QUEUE_DEPTH];
    logic [COUNT_BITS-1:0] count_reg, count_next, count_base;

    always_comb
    begin
        q_next     = q_reg;
        count_base = count_reg;
        if (pop)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i+1];
            end
            count_base = count_reg - COUNT_BITS'(1);
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if ((push_count != 2'd0) && (COUNT_BITS'(i) == count_base))
            begin
                q_next[i] = tok0;
            end
            if ((push_count == 2'd2) && (COUNT_BITS'(i) == count_base + COUNT_BITS'(1)))
            begin
                q_next[i] = tok1;
            end
        end
        count_next = count_base + COUNT_BITS'(push_count);
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head         = q_reg[0];
    assign status.valid = (count_reg != '0);
    assign status.room  = (count_reg <= COUNT_BITS'(QUEUE_DEPTH - 2));

endmodule

/* src/s_expression_tokenizer_core.sv */
// Top level of the S-expression tokenizer: scanner plus output token queue.
// Depends on sexp_tok_pkg, sexp_tok_scan and sexp_tok_outq.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-------------------------------------------
//   bytes   | data_valid / data_ready   | data_byte, end_of_input
//   tokens  | token_valid / token_ready | token_kind, number_value, symbol_start,
//           |                           | symbol_length, line_number, last_of_run
//
// Each request on the byte channel is scanned in the cycle it is accepted; its
// tokens are registered into the output queue and leave it in order, one per
// cycle while token_ready is high. One byte can be taken every cycle while
// data_ready is high; the four-entry queue absorbs items that yield two tokens.
// Reset clears the scan state to idle, offset zero and line one, and empties
// the queue. A stall on the token side fills the queue; data_ready drops
// once fewer than two entries are free.
module s_expression_tokenizer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                data_valid,
    output logic                                data_ready,
    input  logic [7:0]                          data_byte,
    input  logic                                end_of_input,
    output logic                                token_valid,
    input  logic                                token_ready,
    output logic [2:0]                          token_kind,
    output logic signed [sexp_tok_pkg::NUM_BITS-1:0] number_value,
    output logic [31:0]                         symbol_start,
    output logic [31:0]                         symbol_length,
    output logic [31:0]                         line_number,
    output logic                                last_of_run
);
    import sexp_tok_pkg::*;

    logic         accept;
    token_t       tok0, tok1, head;
    logic [1:0]   tok_count, push_count;
    outq_status_t status;

    // A byte is taken only when the queue can hold both of its possible tokens.
    assign data_ready = status.room;
    assign accept     = data_valid && data_ready;
    assign push_count = accept ? tok_count : 2'd0;

    sexp_tok_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .tok0         (tok0),
        .tok1         (tok1),
        .tok_count    (tok_count)
    );

    sexp_tok_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .tok0       (tok0),
        .tok1       (tok1),
        .pop        (token_valid && token_ready),
        .head       (head),
        .status     (status)
    );

    // The head of the queue drives the token channel directly.
    assign token_valid   = status.valid;
    assign token_kind    = head.kind;
    assign number_value  = head.num;
    assign symbol_start  = head.start;
    assign symbol_length = head.len;
    assign line_number   = head.line;
    assign last_of_run   = head.last;

endmodule

/* sim/tb_s_expression_tokenizer_core.sv */
// Self-checking testbench for s_expression_tokenizer_core: streams source bytes,
// predicts every token and compares each one field by field as it leaves the block.
// Depends on sexp_tok_pkg and the RTL of s_expression_tokenizer_core.
module tb_s_expression_tokenizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sexp_tok_pkg::*;

    // Cycles without any accepted request on either channel before the run
    // is declared hung. The longest legal quiet stretch is a receiver hold-off.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 900;

    // One request on the byte channel.
    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
    } byte_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        data_valid = 1'b0;
    logic        data_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_input = 1'b0;
    logic        token_valid;
    logic        token_ready = 1'b0;
    logic [2:0]  token_kind;
    logic signed [NUM_BITS-1:0] number_value;
    logic [31:0] symbol_start;
    logic [31:0] symbol_length;
    logic [31:0] line_number;
    logic        last_of_run;

    s_expression_tokenizer_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token_kind   (token_kind),
        .number_value (number_value),
        .symbol_start (symbol_start),
        .symbol_length(symbol_length),
        .line_number  (line_number),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Byte requests waiting to be offered, and the tokens the lexer model
    // says must come out, oldest first.
    byte_req_t pending_reqs[$];
    token_t    tokens_due[$];
    int        err_count = 0;

    // Lexer model state. It mirrors the scanner's registers after reset.
    scan_mode_t           lex_mode = MODE_IDLE;
    logic [NUM_BITS-1:0]  num_mag = '0;
    logic                 num_neg = 1'b0;
    logic                 num_sat = 1'b0;
    offset_t              tok_start = '0;
    offset_t              byte_off = '0;
    line_t                line_cnt = 1;

    // Tokens produced by the byte under prediction; a byte yields at most two.
    token_t run_buf[2];
    int     run_len;

    function automatic logic is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_sym(logic [7:0] c);
        return !(c == CH_NUL || is_space(c) || c == CH_OPEN || c == CH_CLOSE ||
                 c == CH_QUOTE || c == CH_SEMI || c == CH_BACKSLASH || c == CH_BAR);
    endfunction

    function void emit_token(token_kind_t kind, logic [NUM_BITS-1:0] num,
                             offset_t start, offset_t len);
        token_t t;
        t.kind  = kind;
        t.num   = num;
        t.start = start;
        t.len   = len;
        t.line  = line_cnt;
        t.last  = 1'b0;
        if (run_len < 2)
        begin
            run_buf[run_len] = t;
            run_len++;
        end
    endfunction

    function void bump_line();
        if (line_cnt != LINE_MAX)
        begin
            line_cnt++;
        end
    endfunction

    // Accumulate one decimal digit, clamping the magnitude at the limit of
    // the number's sign; once clamped, further digits are dropped.
    function void add_digit(logic [NUM_BITS-1:0] d);
        logic [NUM_BITS-1:0] limit;
        limit = num_neg ? NEG_LIMIT : POS_LIMIT;
        if (!num_sat)
        begin
            if (num_mag > (limit - d) / 10)
            begin
                num_mag = limit;
                num_sat = 1'b1;
            end
            else
            begin
                num_mag = num_mag * 10 + d;
            end
        end
    endfunction

    function void start_number(logic [NUM_BITS-1:0] d, logic neg);
        lex_mode = MODE_NUMBER;
        num_neg  = neg;
        num_sat  = 1'b0;
        num_mag  = '0;
        add_digit(d);
    endfunction

    // Close whatever token is open at offset off.
    function void flush_token(offset_t off);
        case (lex_mode)
            MODE_MINUS:
                emit_token(KIND_SYM, '0, tok_start, 1);
            MODE_NUMBER:
                emit_token(KIND_NUM, num_neg ? -num_mag : num_mag, '0, '0);
            MODE_SYMBOL, MODE_BAR:
                emit_token(KIND_SYM, '0, tok_start, off - tok_start);
            default:
                ;
        endcase
        lex_mode = MODE_IDLE;
    endfunction

    // Scan a byte that arrives between tokens.
    function void scan_between(logic [7:0] c, offset_t off);
        if (is_space(c))
        begin
            if (c == CH_NEWLINE)
            begin
                bump_line();
            end
        end
        else if (c == CH_SEMI)
            lex_mode = MODE_COMMENT;
        else if (c == CH_OPEN)
            emit_token(KIND_OPEN, '0, '0, '0);
        else if (c == CH_CLOSE)
            emit_token(KIND_CLOSE, '0, '0, '0);
        else if (c == CH_QUOTE)
            emit_token(KIND_QUOTE, '0, '0, '0);
        else if (c == CH_DOT)
            emit_token(KIND_DOT, '0, '0, '0);
        else if (c == CH_MINUS)
        begin
            lex_mode  = MODE_MINUS;
            tok_start = off;
        end
        else if (is_digit(c))
            start_number(NUM_BITS'(c - CH_ZERO), 1'b0);
        else if (c == CH_BAR)
        begin
            lex_mode  = MODE_BAR;
            tok_start = off + 1;
        end
        else if (is_sym(c))
        begin
            lex_mode  = MODE_SYMBOL;
            tok_start = off;
        end
        else
            emit_token(KIND_ERR, '0, '0, '0);
    endfunction

    // Advance the lexer model by one accepted request and queue its tokens.
    function void lex_byte(logic [7:0] c, logic eoi);
        offset_t off;
        token_t  t;
        off = byte_off;
        run_len = 0;
        if (eoi)
        begin
            flush_token(off);
            emit_token(KIND_END, '0, '0, '0);
        end
        else
        begin
            byte_off = off + 1;
            case (lex_mode)
                MODE_COMMENT:
                begin
                    if (c == CH_NEWLINE)
                    begin
                        bump_line();
                        lex_mode = MODE_IDLE;
                    end
                end
                MODE_MINUS:
                begin
                    if (is_digit(c))
                        start_number(NUM_BITS'(c - CH_ZERO), 1'b1);
                    else
                    begin
                        flush_token(off);
                        scan_between(c, off);
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit(c))
                        add_digit(NUM_BITS'(c - CH_ZERO));
                    else
                    begin
                        flush_token(off);
                        scan_between(c, off);
                    end
                end
                MODE_SYMBOL:
                begin
                    if (!is_sym(c))
                    begin
                        flush_token(off);
                        scan_between(c, off);
                    end
                end
                MODE_BAR:
                begin
                    // Inside bars everything belongs to the symbol, newlines too.
                    if (c == CH_BAR)
                        flush_token(off);
                end
                default:
                begin
                    lex_mode = MODE_IDLE;
                    scan_between(c, off);
                end
            endcase
        end
        for (int i = 0; i < run_len; i++)
        begin
            t = run_buf[i];
            t.last = (i == run_len - 1);
            tokens_due.push_back(t);
        end
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected 0x%h, got 0x%h", name, want, seen);
            err_count++;
        end
    endfunction

    task automatic push_byte(logic [7:0] b);
        pending_reqs.push_back('{data: b, eoi: 1'b0});
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(s[i]);
        end
    endtask

    // The byte that rides along with an end marker is ignored, so it is random.
    task automatic push_eoi();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        pending_reqs.push_back('{data: junk, eoi: 1'b1});
    endtask

    // Driver. A request is loaded when the channel is free and the drawn gap
    // has run out; once raised, valid and payload hold until the handshake.
    // Prediction happens at the edge where the request is accepted.
    byte_req_t next_req;
    int        send_gap = 0;
    bit        send_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_valid   <= 1'b0;
            data_byte    <= 8'h00;
            end_of_input <= 1'b0;
        end
        else
        begin
            if (data_valid && data_ready)
            begin
                lex_byte(data_byte, end_of_input);
            end
            if (!data_valid || data_ready)
            begin
                if (send_gap == 0 && pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    data_valid   <= 1'b1;
                    data_byte    <= next_req.data;
                    end_of_input <= next_req.eoi;
                    // Bursts with no idling alternate with stretches of random gaps.
                    if ($urandom_range(0, 47) == 0)
                    begin
                        send_burst = !send_burst;
                    end
                    send_gap = send_burst ? 0 : $urandom_range(0, 15);
                end
                else
                begin
                    data_valid <= 1'b0;
                    if (send_gap > 0)
                    begin
                        send_gap--;
                    end
                end
            end
        end
    end

    // Monitor. Each accepted token is checked against the oldest prediction.
    // After every token the receiver draws a stall; now and then it holds
    // off for a long stretch so the output queue fills and data_ready drops.
    token_t want_tok;
    int     recv_gap = 0;
    int     hold_cnt = 0;
    int     tokens_taken = 0;
    bit     recv_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_ready <= 1'b0;
        end
        else
        begin
            if (token_valid && token_ready)
            begin
                if (tokens_due.size() == 0)
                begin
                    $error("token with no request behind it: kind %0d", token_kind);
                    err_count++;
                end
                else
                begin
                    want_tok = tokens_due.pop_front();
                    check_field("token_kind", 64'(want_tok.kind), 64'(token_kind));
                    check_field("number_value", want_tok.num, number_value);
                    check_field("symbol_start", 64'(want_tok.start), 64'(symbol_start));
                    check_field("symbol_length", 64'(want_tok.len), 64'(symbol_length));
                    check_field("line_number", 64'(want_tok.line), 64'(line_number));
                    check_field("last_of_run", 64'(want_tok.last), 64'(last_of_run));
                end
                tokens_taken++;
                if (tokens_taken % 100 == 40)
                begin
                    hold_cnt = HOLD_OFF_CYCLES;
                end
                if ($urandom_range(0, 47) == 0)
                begin
                    recv_burst = !recv_burst;
                end
                recv_gap = recv_burst ? 0 : $urandom_range(0, 15);
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                token_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                token_ready <= 1'b0;
            end
            else
            begin
                token_ready <= 1'b1;
            end
        end
    end

    // Watchdog: any accepted request on either channel restarts the count.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((data_valid && data_ready) || (token_valid && token_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("s_expression_tokenizer_core test failed");
        $finish;
    end

    // Stimulus and end of run. The whole request list is built before reset
    // is released, so the driver never sees a partly filled queue.
    initial
    begin
        logic [7:0] b;
        int         n;

        // Directed part: every token kind, a lone minus before a symbol byte,
        // a dot between tokens, a negative number cut by a close paren, a
        // backslash and a NUL as unknown bytes, a bar symbol holding a
        // newline, a lone minus and an unterminated bar symbol flushed by
        // end of input, and a comment ended silently by end of input.
        push_text("('-x .5-7)ab");
        push_byte(CH_BACKSLASH);
        push_text("|q\n|");
        push_byte(CH_NUL);
        push_text(";z\n-");
        push_eoi();
        push_text("|r");
        push_eoi();
        push_byte(CH_SEMI);
        push_eoi();

        // Random part: mostly well-formed fragments with random content,
        // with noise bytes and broken fragments mixed in.
        while (pending_reqs.size() < RANDOM_ITEMS + 28)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    if ($urandom_range(0, 2) == 0)
                        push_byte(CH_MINUS);
                    n = $urandom_range(1, 4);
                    repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                end
                3:
                begin
                    // Long numbers, many of them past the saturation point.
                    if ($urandom_range(0, 1) == 0)
                        push_byte(CH_MINUS);
                    push_byte($urandom_range(0, 1) ? CH_NINE
                                                   : CH_ZERO + 8'($urandom_range(0, 9)));
                    n = $urandom_range(16, 20);
                    repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                end
                4:
                begin
                    // Right at the positive and negative limits and one past them.
                    if ($urandom_range(0, 1) == 0)
                        push_byte(CH_MINUS);
                    push_text("922337203685477580");
                    push_byte(CH_ZERO + 8'($urandom_range(5, 9)));
                end
                5, 6, 7:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                    begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (!is_sym(b));
                        push_byte(b);
                    end
                end
                8:
                begin
                    push_byte(CH_BAR);
                    n = $urandom_range(0, 5);
                    repeat (n)
                    begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b == CH_BAR);
                        push_byte($urandom_range(0, 3) == 0 ? CH_NEWLINE : b);
                    end
                    if ($urandom_range(0, 7) == 0)
                        push_eoi();
                    else
                        push_byte(CH_BAR);
                end
                9:
                begin
                    push_byte(CH_SEMI);
                    n = $urandom_range(0, 4);
                    repeat (n)
                    begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b == CH_NEWLINE);
                        push_byte(b);
                    end
                    if ($urandom_range(0, 5) == 0)
                        push_eoi();
                    else
                        push_byte(CH_NEWLINE);
                end
                10, 11, 12:
                begin
                    case ($urandom_range(0, 3))
                        0: push_byte(CH_OPEN);
                        1: push_byte(CH_CLOSE);
                        2: push_byte(CH_QUOTE);
                        default: push_byte(CH_DOT);
                    endcase
                end
                13, 14, 15:
                begin
                    b = 8'($urandom_range(8, 13));
                    push_byte(b == 8 ? CH_SPACE : b);
                end
                16:
                    push_eoi();
                17:
                    push_byte(CH_MINUS);
                default:
                    push_byte(8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                b = 8'($urandom_range(8, 13));
                push_byte(b == 8 ? CH_SPACE : b);
            end
        end
        push_eoi();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Let the driver use up every request, then let the tokens drain.
        while (pending_reqs.size() != 0 || data_valid)
        begin
            @(posedge clk);
        end
        while (tokens_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tokens_due.size() != 0)
        begin
            $error("%0d predicted tokens never arrived", tokens_due.size());
            err_count++;
        end
        if (err_count == 0)
            $display("s_expression_tokenizer_core test passed");
        else
            $display("s_expression_tokenizer_core test failed");
        $finish;
    end

endmodule
